### rtl/core/tkfv_pkg.sv
// Package for top_k_frequent_values: widths, defaults and register codes.
// No dependencies.
package tkfv_pkg;
    localparam int unsigned TableEntries = 256;
    localparam int unsigned KMax = 16;
    localparam int unsigned CountBits = 16;
    localparam int unsigned ValueBits = 32;
    localparam int unsigned TopCountBits = 5;
    localparam int unsigned AddrBits = 1;
    localparam logic [AddrBits-1:0] REG_TOP_COUNT = 1'b0;

    // Cell status toward the controller.
    typedef struct packed {
        logic hit;
        logic used;
    } cell_stat_t;
endpackage

### rtl/core/tkfv_cell.sv
// One table cell: holds a value and its count, matches the broadcast value,
// and takes part in the rank scan. Depends on tkfv_pkg.
module tkfv_cell #(
    parameter int unsigned COUNT_W = tkfv_pkg::CountBits
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [31:0]            bcast_value,
    input  logic                   count_en,   // a value is being counted
    input  logic                   alloc,      // this cell takes the new value
    input  logic                   clear,      // end of set
    input  logic                   remove,     // selected as winner
    output tkfv_pkg::cell_stat_t   stat,
    output logic [COUNT_W+31:0]    key,        // {count, value ^ sign}
    output logic [31:0]            value_out,
    output logic [COUNT_W-1:0]     count_out
);
    logic [31:0]        value_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               used_reg;

    assign stat.hit  = used_reg && (value_reg == bcast_value);
    assign stat.used = used_reg;
    assign key       = {count_reg, value_reg ^ 32'h8000_0000};
    assign value_out = value_reg;
    assign count_out = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (clear || remove) begin
            used_reg <= 1'b0;
        end else if (alloc) begin
            used_reg <= 1'b1;
        end
        if (alloc) begin
            value_reg <= bcast_value;
            count_reg <= COUNT_W'(1);
        end else if (count_en && stat.hit && count_reg != {COUNT_W{1'b1}}) begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end
endmodule

### rtl/core/tkfv_rank.sv
// Ranking unit: registered max tree over the cell keys, with a register at every tree level.
// Depends on tkfv_pkg.
module tkfv_rank #(
    parameter int unsigned N      = tkfv_pkg::TableEntries,
    parameter int unsigned KEY_W  = 48
) (
    input  logic                  aclk,
    input  logic [N-1:0]          valid_in,
    input  logic [N*KEY_W-1:0]    keys_in,
    output logic                  valid_out,
    output logic [$clog2(N)-1:0]  idx_out,
    output logic [KEY_W-1:0]      key_out
);
    localparam int unsigned L  = $clog2(N);
    localparam int unsigned W  = 1 << L;
    localparam int unsigned IW = (L < 1) ? 1 : L;

    logic [KEY_W-1:0] k_reg [L+1][W];
    logic [IW-1:0]    i_reg [L+1][W];
    logic             v_reg [L+1][W];

    always_comb begin
        for (int j = 0; j < W; j++) begin
            k_reg[0][j] = (j < N) ? keys_in[j*KEY_W +: KEY_W] : '0;
            i_reg[0][j] = IW'(j);
            v_reg[0][j] = (j < N) ? valid_in[j] : 1'b0;
        end
    end

    for (genvar l = 0; l < L; l++) begin : g_lvl
        for (genvar j = 0; j < (W >> (l + 1)); j++) begin : g_node
            always_ff @(posedge aclk) begin
                if (v_reg[l][2*j] && (!v_reg[l][2*j+1] ||
                        k_reg[l][2*j] > k_reg[l][2*j+1])) begin
                    k_reg[l+1][j] <= k_reg[l][2*j];
                    i_reg[l+1][j] <= i_reg[l][2*j];
                end else begin
                    k_reg[l+1][j] <= k_reg[l][2*j+1];
                    i_reg[l+1][j] <= i_reg[l][2*j+1];
                end
                v_reg[l+1][j] <= v_reg[l][2*j] || v_reg[l][2*j+1];
            end
        end
        for (genvar j = (W >> (l + 1)); j < W; j++) begin : g_pad
            assign k_reg[l+1][j] = '0;
            assign i_reg[l+1][j] = '0;
            assign v_reg[l+1][j] = 1'b0;
        end
    end

    assign valid_out = v_reg[L][0];
    assign idx_out   = i_reg[L][0][L-1:0];
    assign key_out   = k_reg[L][0];
endmodule

### rtl/core/top_k_frequent_values.sv
// top_k_frequent_values: counts distinct signed values in a row of cells and
// reports the k most frequent on the last item. Depends on tkfv_pkg, tkfv_cell, tkfv_rank.
// Throughput: one value per cycle while counting (all cells match in parallel).
// Last item: report takes one round through the max tree per result (k, at most the cells in use),
// each result then held in an output register until taken; input stalls meanwhile.
// Reset (synchronous, active low): table empty, overflow clear, top_count = 1.
module top_k_frequent_values #(
    parameter int unsigned TABLE_ENTRIES = tkfv_pkg::TableEntries,
    parameter int unsigned K_MAX         = tkfv_pkg::KMax,
    parameter int unsigned COUNT_BITS    = tkfv_pkg::CountBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input: tdata = value[31:0]; tlast = last_item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    // result: tdata = frequent_value[31:0], occurrences[47:32];
    // tuser = table_overflow; tlast = last_result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tkfv_pkg::AddrBits+1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned N     = TABLE_ENTRIES;
    localparam int unsigned IB    = $clog2(N);
    localparam int unsigned KEY_W = COUNT_BITS + 32;
    localparam int unsigned LAT   = IB;          // tree depth
    localparam int unsigned KB    = $clog2(K_MAX + 1);
    localparam int unsigned WB    = $clog2(LAT + 2);

    typedef enum logic [1:0] {ST_COUNT, ST_SEL, ST_OUT} state_t;

    logic [tkfv_pkg::TopCountBits-1:0] top_count_reg;
    state_t state_reg;
    logic   ovf_reg;
    logic [KB-1:0] left_reg;    // results still to send
    logic [WB-1:0] wait_reg;
    logic [IB:0]   ent_reg;     // cells in use
    logic [N-1:0]  remove_vec;

    tkfv_pkg::cell_stat_t stat [N];
    logic [N-1:0]         hit_vec, used_vec;
    logic [N*KEY_W-1:0]   keys;
    logic [31:0]          vals [N];
    logic [COUNT_BITS-1:0] cnts [N];
    logic [N-1:0]         alloc_vec;
    logic                 count_en, clear_all, any_hit, full;
    logic                 tree_v;
    logic [IB-1:0]        tree_i;
    logic [KEY_W-1:0]     tree_k;
    logic [IB:0]          ent_after;
    logic [KB-1:0]        k_clamp, left_init;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[tkfv_pkg::AddrBits+1:2] == tkfv_pkg::REG_TOP_COUNT)
                    ? 32'(top_count_reg) : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= 5'd1;
        end else if (psel && penable && pwrite &&
                     paddr[tkfv_pkg::AddrBits+1:2] == tkfv_pkg::REG_TOP_COUNT) begin
            top_count_reg <= pwdata[tkfv_pkg::TopCountBits-1:0];
        end
    end

    // the cell row
    assign s_tready = (state_reg == ST_COUNT);
    assign count_en = s_tvalid && s_tready;
    always_comb begin
        for (int j = 0; j < N; j++) begin
            hit_vec[j]  = stat[j].hit;
            used_vec[j] = stat[j].used;
        end
        any_hit = |hit_vec;
        full    = &used_vec;
        // cells fill from cell 0 up and are not freed while counting (only during a report),
        // so the first free cell is the one whose left neighbor is in use
        alloc_vec = '0;
        if (count_en && !any_hit) begin
            alloc_vec[0] = ~used_vec[0];
            for (int j = 1; j < N; j++)
                alloc_vec[j] = ~used_vec[j] & used_vec[j-1];
        end
    end

    // number of results: k clamped to 1..K_MAX, at most the cells in use
    always_comb begin
        ent_after = (count_en && !any_hit && !full) ? ent_reg + (IB+1)'(1) : ent_reg;
        if (top_count_reg == '0)
            k_clamp = KB'(1);
        else if (32'(top_count_reg) > K_MAX)
            k_clamp = KB'(K_MAX);
        else
            k_clamp = KB'(top_count_reg);
        left_init = (32'(k_clamp) < 32'(ent_after)) ? k_clamp : KB'(ent_after);
    end

    for (genvar j = 0; j < N; j++) begin : g_cell
        tkfv_cell #(.COUNT_W(COUNT_BITS)) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .bcast_value(s_tdata), .count_en(count_en),
            .alloc(alloc_vec[j]), .clear(clear_all), .remove(remove_vec[j]),
            .stat(stat[j]), .key(keys[j*KEY_W +: KEY_W]),
            .value_out(vals[j]), .count_out(cnts[j])
        );
    end

    tkfv_rank #(.N(N), .KEY_W(KEY_W)) u_rank (
        .aclk(aclk), .valid_in(used_vec), .keys_in(keys),
        .valid_out(tree_v), .idx_out(tree_i), .key_out(tree_k)
    );

    // removal frees the winner so the next scan picks the next key
    assign clear_all = (state_reg == ST_OUT) && m_tready && left_reg == KB'(1);
    always_comb begin
        remove_vec = '0;
        if (state_reg == ST_SEL && wait_reg == '0 && tree_v)
            remove_vec[tree_i] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COUNT;
            ovf_reg   <= 1'b0;
            m_tvalid  <= 1'b0;
            left_reg  <= '0;
            wait_reg  <= '0;
            ent_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_COUNT: begin
                    if (count_en) begin
                        ent_reg <= ent_after;
                        if (!any_hit && full) ovf_reg <= 1'b1;
                        if (s_tlast) begin
                            left_reg  <= left_init;
                            wait_reg  <= WB'(LAT + 1);
                            state_reg <= ST_SEL;
                        end
                    end
                end
                ST_SEL: begin
                    if (wait_reg != '0) begin
                        wait_reg <= wait_reg - WB'(1);
                    end else begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {16'(tree_k[KEY_W-1 -: COUNT_BITS]), vals[tree_i]};
                        m_tuser   <= ovf_reg;
                        m_tlast   <= (left_reg == KB'(1));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        if (left_reg == KB'(1)) begin
                            ovf_reg   <= 1'b0;
                            ent_reg   <= '0;
                            state_reg <= ST_COUNT;
                        end else begin
                            left_reg  <= left_reg - KB'(1);
                            wait_reg  <= WB'(LAT + 1);
                            state_reg <= ST_SEL;
                        end
                    end
                end
                default: state_reg <= ST_COUNT;
            endcase
        end
    end
endmodule

### sim/top_k_frequent_values_test.sv
// Self-checking testbench for top_k_frequent_values: directed table, k and stall cases, then random sets.
// Depends on tkfv_pkg and the top_k_frequent_values RTL.
`timescale 1ns / 1ps

module top_k_frequent_values_test;

    localparam int Period = 8;
    localparam int IdleLimit = 20000;
    localparam int RandomItems = 150;

    // one expected result transfer
    typedef struct packed {
        logic [31:0] value;
        logic [15:0] count;
        logic        last;
        logic        ovf;
    } ranked_t;

    // directed row: value, last flag, expected top entry when typed in
    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        known;
        logic [31:0] top_value;
        logic [15:0] top_count_exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // value
    logic        s_tlast = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // frequent_value[31:0], occurrences[47:32]
    logic        m_tlast;        // last_result
    logic        m_tuser;        // table_overflow
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [tkfv_pkg::AddrBits+1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    top_k_frequent_values dut (.*);

    always #(Period / 2) aclk = ~aclk;

    // predictor state
    logic [31:0] tbl_value [tkfv_pkg::TableEntries];
    logic [15:0] tbl_count [tkfv_pkg::TableEntries];
    int          tbl_used;
    logic        tbl_ovf;
    logic [4:0]  k_setting;

    ranked_t     ranked_q[$];
    int          failures = 0;
    int          idle_cycles = 0;
    bit          sender_done = 0;
    bit          hold_off = 0;     // long receiver stall request

    // count one value; on last, queue the ranked report
    task automatic count_value(input logic [31:0] v, input logic last);
        int hit;
        int n, k, best;
        logic [63:0] key, best_key, prev_key;
        ranked_t item;
        hit = -1;
        for (int i = 0; i < tbl_used; i++)
            if (tbl_value[i] == v && hit < 0) hit = i;
        if (hit >= 0) begin
            if (tbl_count[hit] != 16'hFFFF) tbl_count[hit]++;
        end else if (tbl_used < tkfv_pkg::TableEntries) begin
            tbl_value[tbl_used] = v;
            tbl_count[tbl_used] = 16'd1;
            tbl_used++;
        end else begin
            tbl_ovf = 1'b1;
        end
        if (!last) return;
        k = (k_setting == 0) ? 1 :
            (k_setting > tkfv_pkg::KMax ? tkfv_pkg::KMax : k_setting);
        n = (tbl_used < k) ? tbl_used : k;
        prev_key = '1;
        for (int r = 0; r < n; r++) begin
            best = -1;
            best_key = '0;
            for (int i = 0; i < tbl_used; i++) begin
                // count high, value with sign flipped low
                key = {16'd0, tbl_count[i], tbl_value[i] ^ 32'h8000_0000};
                if ((r == 0 || key < prev_key) && (best < 0 || key > best_key)) begin
                    best = i;
                    best_key = key;
                end
            end
            prev_key = best_key;
            item = {tbl_value[best], tbl_count[best], r == n - 1, tbl_ovf};
            ranked_q.insert(ranked_q.size(), item);
        end
        tbl_used = 0;
        tbl_ovf = 1'b0;
    endtask

    task automatic write_top_count(input logic [31:0] k);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {tkfv_pkg::REG_TOP_COUNT, 2'b00}; pwdata <= k;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        k_setting = k[4:0];
    endtask

    // one input transfer, with a random gap beforehand if gaps is set; returns at the next
    // falling edge with tvalid still high, so a following item can go back to back
    task automatic send_value(input logic [31:0] v, input logic last, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= v; s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        count_value(v, last);
        @(negedge aclk);
    endtask

    // drop the input and wait for every expected result
    task automatic drain;
        s_tvalid <= 1'b0;
        while (ranked_q.size() != 0) @(negedge aclk);
        repeat (tkfv_pkg::TableEntries * 2) @(negedge aclk); // let the rank pass settle
    endtask

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        int wait_n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid && !hold_off);
            end
        end
    end

    // checker on result transfers
    always @(posedge aclk) begin
        ranked_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (ranked_q.size() == 0) begin
                $display("%0t: unexpected result value=%h count=%0d", $time,
                         m_tdata[31:0], m_tdata[47:32]);
                failures++;
            end else begin
                exp_r = ranked_q.pop_front();
                if (exp_r.value !== m_tdata[31:0] || exp_r.count !== m_tdata[47:32] ||
                    exp_r.last !== m_tlast || exp_r.ovf !== m_tuser) begin
                    $display("%0t: expected value=%h count=%0d last=%b ovf=%b, got %h %0d %b %b",
                             $time, exp_r.value, exp_r.count, exp_r.last, exp_r.ovf,
                             m_tdata[31:0], m_tdata[47:32], m_tlast, m_tuser);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("top_k_frequent_values_test NOT OK");
            $finish;
        end
    end

    row_t rows[$];

    task automatic add_row(input logic [31:0] v, input logic last, input logic known = 0,
                           input logic [31:0] tv = 0, input logic [15:0] tc = 0);
        row_t row;
        row = '{v, last, known, tv, tc};
        rows.insert(rows.size(), row);
    endtask

    initial begin
        int sent, set_len, pool;
        logic [31:0] vals [8];
        tbl_used = 0; tbl_ovf = 0; k_setting = 5'd1;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: k = 1 after reset, extremes, tie broken toward larger value
        add_row(32'h8000_0000, 1, 1, 32'h8000_0000, 16'd1);
        add_row(32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 16'd1);
        add_row(32'hFFFF_FFFF, 0);
        add_row(32'h0000_0000, 1, 1, 32'h0000_0000, 16'd1);  // tie: 0 beats -1
        add_row(32'h8000_0000, 0);
        add_row(32'h8000_0000, 0);
        add_row(32'h7FFF_FFFF, 1, 1, 32'h8000_0000, 16'd2);
        foreach (rows[i]) begin
            // earlier reports are taken before the block accepts this item,
            // so the queue head is this row's top entry
            send_value(rows[i].value, rows[i].last, 1);
            if (rows[i].known) begin
                if (ranked_q.size() == 0) begin
                    $display("%0t: expected top %h/%0d in row %0d, got none", $time,
                             rows[i].top_value, rows[i].top_count_exp, i);
                    failures++;
                end else if (ranked_q[0].value !== rows[i].top_value ||
                             ranked_q[0].count !== rows[i].top_count_exp) begin
                    $display("%0t: expected top %h/%0d in row %0d, got %h/%0d", $time,
                             rows[i].top_value, rows[i].top_count_exp, i,
                             ranked_q[0].value, ranked_q[0].count);
                    failures++;
                end
            end
        end
        drain();

        // k above range saturates, fewer distinct than k, k = 0 treated as 1
        write_top_count(31);
        for (int i = 0; i < 5; i++) send_value(i * 3, i == 4, 1);
        drain();
        write_top_count(0);
        send_value(5, 0, 1); send_value(6, 1, 1);
        drain();

        // receiver holds off long while the sender keeps offering a set
        write_top_count(tkfv_pkg::KMax);
        hold_off = 1;
        fork
            begin repeat (400) @(negedge aclk); hold_off = 0; end
            begin
                for (int s = 0; s < 3; s++)
                    for (int i = 0; i < 20; i++) send_value(i, i == 19, 0);
                drain();
            end
        join

        // random sets: small value pools so counts and ties build up
        sent = 0;
        while (sent < RandomItems) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                write_top_count($urandom_range(1, tkfv_pkg::KMax));
            end
            set_len = $urandom_range(1, 20);
            pool = $urandom_range(1, 8);
            foreach (vals[j]) vals[j] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 5);
            for (int i = 0; i < set_len; i++)
                send_value(vals[$urandom_range(0, pool - 1)], i == set_len - 1, 1);
            sent += set_len;
        end
        drain();

        if (failures == 0)
            $display("top_k_frequent_values_test OK");
        else
            $display("top_k_frequent_values_test NOT OK");
        $finish;
    end
endmodule
